// ===== rtl/rhe_pkg.sv =====
// ----------------------------------------------------------------------------
// rhe_pkg
// Shared types and constants for the rule heuristic evaluator.
// ----------------------------------------------------------------------------
package rhe_pkg;

  localparam int DEFAULT_COUNT_BITS = 32;
  localparam int DEFAULT_FRAC_BITS  = 30;
  localparam int DATA_W             = 32;
  localparam int ADDR_W             = 4;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SELECT = 2'd0;
  localparam logic [1:0] REG_BETA   = 2'd1;
  localparam logic [1:0] REG_M      = 2'd2;

  // heuristic_select codes
  localparam logic [2:0] HS_PRECISION = 3'd0;
  localparam logic [2:0] HS_RECALL    = 3'd1;
  localparam logic [2:0] HS_WRA       = 3'd2;
  localparam logic [2:0] HS_HAMMING   = 3'd3;
  localparam logic [2:0] HS_FMEASURE  = 3'd4;
  localparam logic [2:0] HS_MESTIMATE = 3'd5;

  localparam logic [31:0] WEIGHT_INF   = 32'hFFFF_FFFF;
  localparam logic [31:0] WEIGHT_RESET = 32'h0001_0000;

  // effective heuristic after the special weights are folded in
  typedef enum logic [2:0] {
    MODE_PREC,
    MODE_REC,
    MODE_WRA,
    MODE_HAM,
    MODE_FM,
    MODE_ME,
    MODE_ONE
  } mode_t;

  typedef struct packed {
    logic valid;
    logic force_one;
  } div_ctrl_t;

endpackage

// ===== rtl/rule_heuristic_evaluator.sv =====
// ----------------------------------------------------------------------------
// rule_heuristic_evaluator
// Scores a candidate rule from its eight confusion-matrix counts with a
// selectable heuristic; unsigned fixed-point loss out.
// ----------------------------------------------------------------------------
// channel   direction  handshake            words
// input     in         in_valid / in_stall  eight counts
// output    out        out_valid / out_stall score
// config    in         APB write/read       heuristic_select, beta, m
//
// One word per cycle sustained while the output is not stalled. The chain has
// four front stages, then one division cell per quotient bit.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole chain; in_stall follows it.
// ----------------------------------------------------------------------------
module rule_heuristic_evaluator #(
  parameter int COUNT_BITS = rhe_pkg::DEFAULT_COUNT_BITS,
  parameter int FRAC_BITS  = rhe_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                cov_irr_neg,
  input  logic [31:0]                cov_irr_pos,
  input  logic [31:0]                cov_rel_neg,
  input  logic [31:0]                cov_rel_pos,
  input  logic [31:0]                unc_irr_neg,
  input  logic [31:0]                unc_irr_pos,
  input  logic [31:0]                unc_rel_neg,
  input  logic [31:0]                unc_rel_pos,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                score,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rhe_pkg::ADDR_W-1:0] paddr,
  input  logic [rhe_pkg::DATA_W-1:0] pwdata,
  output logic [rhe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rhe_pkg::*;

  localparam int IW = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam int DW = IW + 68;
  localparam int QW = FRAC_BITS + 1;
  localparam logic [31:0] ONE_SCORE =
    (FRAC_BITS >= 32) ? 32'hFFFF_FFFF : 32'(64'd1 << FRAC_BITS);

  // configuration registers
  logic [2:0]  heuristic_select;
  logic [31:0] beta_weight, m_weight;
  logic [63:0] beta_sq;
  logic [1:0]  reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heuristic_select <= HS_PRECISION;
      beta_weight      <= WEIGHT_RESET;
      m_weight         <= WEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SELECT: heuristic_select <= pwdata[2:0];
        REG_BETA:   beta_weight      <= pwdata;
        REG_M:      m_weight         <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    beta_sq <= beta_weight * beta_weight;
  end

  always_comb begin
    unique case (reg_idx)
      REG_SELECT: prdata = {29'd0, heuristic_select};
      REG_BETA:   prdata = beta_weight;
      REG_M:      prdata = m_weight;
      default:    prdata = '0;
    endcase
  end

  // pipeline enable
  logic en;
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  logic [7:0][IW-1:0] cnt;
  assign cnt[0] = cov_irr_neg[IW-1:0];
  assign cnt[1] = cov_irr_pos[IW-1:0];
  assign cnt[2] = cov_rel_neg[IW-1:0];
  assign cnt[3] = cov_rel_pos[IW-1:0];
  assign cnt[4] = unc_irr_neg[IW-1:0];
  assign cnt[5] = unc_irr_pos[IW-1:0];
  assign cnt[6] = unc_rel_neg[IW-1:0];
  assign cnt[7] = unc_rel_pos[IW-1:0];

  div_ctrl_t     ctrl [0:QW];
  logic [DW:0]   rem  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [DW-1:0] front_num;

  rhe_front #(.IW(IW), .DW(DW)) u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (in_valid),
    .cnt              (cnt),
    .heuristic_select (heuristic_select),
    .beta_weight      (beta_weight),
    .m_weight         (m_weight),
    .beta_sq          (beta_sq),
    .ctrl             (ctrl[0]),
    .num              (front_num),
    .den              (den[0])
  );

  assign rem[0] = (DW+1)'(front_num);
  assign q[0]   = '0;

  // cell k resolves quotient bit QW-1-k; the first one takes the integer bit
  for (genvar k = 0; k < QW; k++) begin : g_cell
    rhe_div_cell #(
      .DW    (DW),
      .QW    (QW),
      .BIT   (QW - 1 - k),
      .SHIFT (k != 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (ctrl[k]),
      .rem_in   (rem[k]),
      .den_in   (den[k]),
      .q_in     (q[k]),
      .ctrl_out (ctrl[k+1]),
      .rem_out  (rem[k+1]),
      .den_out  (den[k+1]),
      .q_out    (q[k+1])
    );
  end

  logic [QW+31:0] qx;
  assign qx = (QW+32)'(q[QW]);

  always_comb begin
    if (ctrl[QW].force_one)   score = ONE_SCORE;
    else if (|qx[QW+31:32])   score = 32'hFFFF_FFFF;
    else                      score = qx[31:0];
  end

  assign out_valid = ctrl[QW].valid;

endmodule

// ===== rtl/rhe_front.sv =====
// ----------------------------------------------------------------------------
// rhe_front
// Four-stage front end: count sums, products, then numerator and
// denominator of the selected heuristic.
// ----------------------------------------------------------------------------
module rhe_front #(
  parameter int IW = 32,
  parameter int DW = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [7:0][IW-1:0]     cnt,
  input  logic [2:0]             heuristic_select,
  input  logic [31:0]            beta_weight,
  input  logic [31:0]            m_weight,
  input  logic [63:0]            beta_sq,
  output rhe_pkg::div_ctrl_t     ctrl,
  output logic [DW-1:0]          num,
  output logic [DW-1:0]          den
);
  import rhe_pkg::*;

  localparam int SW = IW + 3;

  // stage 1: sums
  logic [IW:0]   ce_c, inc_c, unc_c;
  logic [IW+1:0] cov_c, e_c, wrong_c;
  logic [SW-1:0] t_c;
  mode_t         mode_c;
  logic          force_c;

  logic          v1;
  mode_t         s1_mode;
  logic          s1_force;
  logic [IW:0]   s1_ce, s1_inc, s1_unc;
  logic [IW+1:0] s1_cov, s1_e, s1_wrong;
  logic [SW-1:0] s1_t, s1_tme;

  always_comb begin
    ce_c    = (IW+1)'(cnt[0]) + (IW+1)'(cnt[3]);
    inc_c   = (IW+1)'(cnt[1]) + (IW+1)'(cnt[2]);
    unc_c   = (IW+1)'(cnt[4]) + (IW+1)'(cnt[7]);
    cov_c   = (IW+2)'(ce_c) + (IW+2)'(inc_c);
    e_c     = (IW+2)'(ce_c) + (IW+2)'(unc_c);
    wrong_c = (IW+2)'(inc_c) + (IW+2)'(cnt[6]) + (IW+2)'(cnt[7]);
    t_c     = SW'(cov_c) + SW'(cnt[4]) + SW'(cnt[5]) + SW'(cnt[6]) + SW'(cnt[7]);
    unique case (heuristic_select)
      HS_PRECISION: mode_c = MODE_PREC;
      HS_RECALL:    mode_c = MODE_REC;
      HS_WRA:       mode_c = MODE_WRA;
      HS_HAMMING:   mode_c = MODE_HAM;
      HS_FMEASURE: begin
        if (beta_weight == WEIGHT_INF) mode_c = MODE_REC;
        else if (beta_weight == '0)    mode_c = MODE_PREC;
        else                           mode_c = MODE_FM;
      end
      HS_MESTIMATE: begin
        if (m_weight == WEIGHT_INF) mode_c = MODE_WRA;
        else if (m_weight == '0)    mode_c = MODE_PREC;
        else                        mode_c = MODE_ME;
      end
      default: mode_c = MODE_ONE;
    endcase
    unique case (mode_c)
      MODE_REC: force_c = (e_c == '0);
      MODE_FM:  force_c = (cov_c == '0) && (unc_c == '0);
      MODE_ONE: force_c = 1'b1;
      default:  force_c = (cov_c == '0);
    endcase
  end

  // stage 2: products
  logic [2*SW-1:0]    t2_c;
  logic [IW+SW:0]     cet_c, inct_c;
  logic [2*IW+3:0]    cove_c;
  logic [IW+SW+1:0]   covt_c;
  logic [SW+31:0]     mt_c, mte_c;
  logic [IW+32:0]     bce_lo_c, bce_hi_c, bunc_lo_c, bunc_hi_c;

  assign t2_c      = s1_t * s1_t;
  assign cet_c     = s1_ce * s1_t;
  assign inct_c    = s1_inc * s1_t;
  assign cove_c    = s1_cov * s1_e;
  assign covt_c    = s1_cov * s1_t;
  assign mt_c      = m_weight * s1_t;
  assign mte_c     = m_weight * s1_tme;
  assign bce_lo_c  = beta_sq[31:0] * s1_ce;
  assign bce_hi_c  = beta_sq[63:32] * s1_ce;
  assign bunc_lo_c = beta_sq[31:0] * s1_unc;
  assign bunc_hi_c = beta_sq[63:32] * s1_unc;

  logic             v2;
  mode_t            s2_mode;
  logic             s2_force;
  logic [IW:0]      s2_inc, s2_unc;
  logic [IW+1:0]    s2_cov, s2_e, s2_wrong;
  logic [SW-1:0]    s2_t;
  logic [2*SW-1:0]  s2_t2;
  logic [IW+SW:0]   s2_cet, s2_inct;
  logic [2*IW+3:0]  s2_cove;
  logic [IW+SW+1:0] s2_covt;
  logic [SW+31:0]   s2_mt, s2_mte;
  logic [IW+32:0]   s2_bce_lo, s2_bce_hi, s2_bunc_lo, s2_bunc_hi;

  // stage 3: combine, pick numerator and denominator
  logic [DW-1:0] wra_num_c, bce_c, bunc_c, m_num_c, m_den_c, n3_c, d3_c;

  always_comb begin
    wra_num_c = DW'(s2_t2) - DW'(s2_cet) + DW'(s2_cove);
    bce_c     = (DW'(s2_bce_hi) << 32) + DW'(s2_bce_lo);
    bunc_c    = (DW'(s2_bunc_hi) << 32) + DW'(s2_bunc_lo);
    m_den_c   = (DW'(s2_covt) << 16) + DW'(s2_mt);
    m_num_c   = (DW'(s2_inct) << 16) + DW'(s2_mte);
    unique case (s2_mode)
      MODE_PREC: begin n3_c = DW'(s2_inc);   d3_c = DW'(s2_cov); end
      MODE_REC:  begin n3_c = DW'(s2_unc);   d3_c = DW'(s2_e);   end
      MODE_WRA:  begin n3_c = wra_num_c;     d3_c = DW'(s2_t2);  end
      MODE_HAM:  begin n3_c = DW'(s2_wrong); d3_c = DW'(s2_t);   end
      MODE_FM:   begin n3_c = bunc_c;        d3_c = bce_c;       end
      MODE_ME:   begin n3_c = m_num_c;       d3_c = m_den_c;     end
      default:   begin n3_c = '0;            d3_c = '0;          end
    endcase
  end

  logic          v3;
  mode_t         s3_mode;
  logic          s3_force;
  logic [IW:0]   s3_inc;
  logic [IW+1:0] s3_cov;
  logic [DW-1:0] s3_n, s3_d;

  // stage 4: F-measure finishes here (s3_n holds beta^2 * unc, s3_d beta^2 * ce)
  logic          v4;
  logic          s4_force;
  logic [DW-1:0] s4_n, s4_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode  <= mode_c;
      s1_force <= force_c;
      s1_ce    <= ce_c;
      s1_inc   <= inc_c;
      s1_unc   <= unc_c;
      s1_cov   <= cov_c;
      s1_e     <= e_c;
      s1_wrong <= wrong_c;
      s1_t     <= t_c;
      s1_tme   <= t_c - SW'(e_c);

      s2_mode    <= s1_mode;
      s2_force   <= s1_force;
      s2_inc     <= s1_inc;
      s2_unc     <= s1_unc;
      s2_cov     <= s1_cov;
      s2_e       <= s1_e;
      s2_wrong   <= s1_wrong;
      s2_t       <= s1_t;
      s2_t2      <= t2_c;
      s2_cet     <= cet_c;
      s2_inct    <= inct_c;
      s2_cove    <= cove_c;
      s2_covt    <= covt_c;
      s2_mt      <= mt_c;
      s2_mte     <= mte_c;
      s2_bce_lo  <= bce_lo_c;
      s2_bce_hi  <= bce_hi_c;
      s2_bunc_lo <= bunc_lo_c;
      s2_bunc_hi <= bunc_hi_c;

      s3_mode  <= s2_mode;
      s3_force <= s2_force;
      s3_inc   <= s2_inc;
      s3_cov   <= s2_cov;
      s3_n     <= n3_c;
      s3_d     <= d3_c;

      s4_force <= s3_force;
      if (s3_mode == MODE_FM) begin
        s4_n <= s3_n + (DW'(s3_inc) << 32);
        s4_d <= s3_d + s3_n + (DW'(s3_cov) << 32);
      end else begin
        s4_n <= s3_n;
        s4_d <= s3_d;
      end
    end
  end

  assign ctrl.valid     = v4;
  assign ctrl.force_one = s4_force;
  assign num            = s4_n;
  assign den            = s4_d;

endmodule

// ===== rtl/rhe_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhe_div_cell
// One restoring-division cell: decides one quotient bit and hands the
// partial remainder to the next cell.
// ----------------------------------------------------------------------------
module rhe_div_cell #(
  parameter int DW    = 100,
  parameter int QW    = 31,
  parameter int BIT   = 0,
  parameter bit SHIFT = 1'b1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rhe_pkg::div_ctrl_t ctrl_in,
  input  logic [DW:0]        rem_in,
  input  logic [DW-1:0]      den_in,
  input  logic [QW-1:0]      q_in,
  output rhe_pkg::div_ctrl_t ctrl_out,
  output logic [DW:0]        rem_out,
  output logic [DW-1:0]      den_out,
  output logic [QW-1:0]      q_out
);
  import rhe_pkg::*;

  logic [DW:0]   r2;
  logic          ge;
  logic [DW:0]   rem_next;
  logic [QW-1:0] q_next;

  // remainder stays below the divisor, so the doubling never drops a bit
  always_comb begin
    r2          = SHIFT ? (rem_in << 1) : rem_in;
    ge          = (r2 >= {1'b0, den_in});
    rem_next    = ge ? (r2 - {1'b0, den_in}) : r2;
    q_next      = q_in;
    q_next[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.force_one <= ctrl_in.force_one;
      rem_out            <= rem_next;
      den_out            <= den_in;
      q_out              <= q_next;
    end
  end

endmodule
